// ----- design/tlrr_pkg.sv -----
// package for the two-level round-robin scheduler
// types, command and status codes and fixed constants; no dependencies
`default_nettype none
package tlrr_pkg;

  localparam int FLAT_LIMIT = 16;
  localparam int SLOT_W     = 9;
  localparam logic [15:0] PERIOD_RST = 16'd1024;
  localparam logic [7:0]  LAST_RST   = 8'hFF;

  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_STALL   = 3'd2;
  localparam logic [2:0] KIND_UNSTALL = 3'd3;
  localparam logic [2:0] KIND_FETCH   = 3'd4;
  localparam logic [2:0] KIND_CYCLE   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] thread_id;
  } in_t;

  typedef struct packed {
    logic [7:0] fetched_thread;
    logic [1:0] status;
    logic       grouped_mode;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_GRP_RD, S_GRP_WR, S_INS_SCAN, S_INS_FREE, S_INS_WR,
    S_FREM_RD, S_FREM_PROC, S_GREM_START, S_GREM_RD, S_GREM_PROC,
    S_FLAT_START, S_FLAT_RD, S_FLAT_WR, S_FMARK_RD, S_FMARK_PROC,
    S_GMARK_START, S_GMARK_RD, S_GMARK_PROC, S_FETCH_WAIT, S_CYC_WAIT, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- design/two_level_round_robin_scheduler.sv -----
// two-level round-robin thread scheduler, top level
// sequencer around one slot memory with one write and one read port; uses tlrr_pkg
`default_nettype none
// One command is taken while busy is low and start is high; its result shows on
// out_data for exactly one cycle under out_strobe, and the receiver cannot stall it.
// All thread slots (GROUP_SIZE*MAX_GROUPS group slots plus a 16-entry flat ring) live
// in one memory with one registered read port, so each slot visited is read first and
// then written or checked. Grouped inserts scan each group in the ring (and the group
// numbers when a new group is opened); remove, stall and unstall read the held threads
// group by group, and a remove that drops below 16 threads copies the remaining threads
// back into the flat ring. The 16th insert regroups the flat ring. rotate_period is
// written through cfg_valid/cfg_ready while the block is idle.
module two_level_round_robin_scheduler #(
  parameter int GROUP_SIZE = 8,
  parameter int MAX_GROUPS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tlrr_pkg::in_t  in_data,
  output logic                out_strobe,
  output tlrr_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [15:0]    cfg_data
);
  import tlrr_pkg::*;

  localparam int CAP   = GROUP_SIZE * MAX_GROUPS;
  localparam int DEPTH = CAP + FLAT_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int GW    = $clog2(MAX_GROUPS);
  localparam int PW    = $clog2(GROUP_SIZE);
  localparam int FW    = $clog2(GROUP_SIZE + 1);
  localparam int CW    = $clog2(MAX_GROUPS + 1);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int NW    = (FW > 5) ? FW : 5;
  localparam int INIT_GROUPS = (FLAT_LIMIT + GROUP_SIZE - 1) / GROUP_SIZE;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] mem_r [0:DEPTH-1];
  logic [SLOT_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [SLOT_W-1:0] mem_wd;

  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic        grouped_r, grouped_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [4:0]  fcount_r, fcount_nxt;
  logic [3:0]  fhead_r, fhead_nxt;
  logic [FW-1:0] fill_r [MAX_GROUPS];
  logic [FW-1:0] fill_nxt [MAX_GROUPS];
  logic [PW-1:0] gh_r [MAX_GROUPS];
  logic [PW-1:0] gh_nxt [MAX_GROUPS];
  logic [GW-1:0] ring_r [MAX_GROUPS];
  logic [GW-1:0] ring_nxt [MAX_GROUPS];
  logic [GW-1:0] ring_rot [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] stl_r, stl_nxt;
  logic [CW-1:0] ring_count_r, ring_count_nxt;
  logic [CW-1:0] ring_idx_r, ring_idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [GW-1:0] best_r, best_nxt;
  logic [FW-1:0] best_fill_r, best_fill_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic        acc_r, acc_nxt;
  logic        found_r, found_nxt;

  logic [GW-1:0] head_g, ring_at, free_g;
  logic [FW-1:0] g_fill;
  logic [PW-1:0] g_head;
  logic          rd_match, idx_at_fill, idx_at_fcount, ring_end;
  logic [15:0]   fc_inc;
  logic [SLOT_W-1:0] mark_val;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [NW-1:0] b);
    logic [NW+1:0] s;
    s = (NW+2)'(a) + (NW+2)'(b);
    if (s >= (NW+2)'(GROUP_SIZE)) s = s - (NW+2)'(GROUP_SIZE);
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [GW-1:0] g, input logic [PW-1:0] p);
    return AW'(g) * AW'(GROUP_SIZE) + AW'(p);
  endfunction

  function automatic logic [AW-1:0] flat_addr(input logic [3:0] p);
    return AW'(CAP) + AW'(p);
  endfunction

  assign head_g        = ring_r[0];
  assign ring_at       = ring_r[ring_idx_r[GW-1:0]];
  assign free_g        = ring_idx_r[GW-1:0];
  assign g_fill        = fill_r[g_r];
  assign g_head        = gh_r[g_r];
  assign rd_match      = (mem_rd_r[7:0] == id_r);
  assign idx_at_fill   = (idx_r == NW'(g_fill));
  assign idx_at_fcount = (idx_r == NW'(fcount_r));
  assign ring_end      = (ring_idx_r == ring_count_r);
  assign fc_inc        = fc_r + 16'd1;
  assign mark_val      = {kind_r == KIND_STALL, id_r};

  always_comb begin
    for (int i = 0; i < MAX_GROUPS; i++) begin
      ring_rot[i] = (CW'(i) == ring_count_r - CW'(1)) ? ring_r[0] : ring_r[(i + 1) % MAX_GROUPS];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (kind_r)
          KIND_INSERT: begin
            if (total_r >= TW'(CAP)) state_nxt = S_DONE;
            else if (grouped_r) state_nxt = S_INS_SCAN;
            else if (total_r + TW'(1) < TW'(FLAT_LIMIT)) state_nxt = S_DONE;
            else state_nxt = S_GRP_RD;
          end
          KIND_REMOVE: state_nxt = grouped_r ? S_GREM_START : S_FREM_RD;
          KIND_STALL, KIND_UNSTALL: state_nxt = grouped_r ? S_GMARK_START : S_FMARK_RD;
          KIND_FETCH: begin
            if (!grouped_r) state_nxt = (fcount_r == 5'd0) ? S_DONE : S_FETCH_WAIT;
            else if (ring_count_r == '0 || fill_r[head_g] == '0) state_nxt = S_DONE;
            else state_nxt = S_FETCH_WAIT;
          end
          KIND_CYCLE: begin
            if (!grouped_r) state_nxt = (fcount_r >= 5'd2) ? S_CYC_WAIT : S_DONE;
            else if (ring_count_r == '0 || stl_r[head_g]) state_nxt = S_DONE;
            else state_nxt = (fill_r[head_g] >= FW'(2)) ? S_CYC_WAIT : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_GRP_RD: state_nxt = S_GRP_WR;
      S_GRP_WR: state_nxt = (idx_r == NW'(FLAT_LIMIT - 1)) ? S_DONE : S_GRP_RD;
      S_INS_SCAN: if (ring_end) state_nxt = found_r ? S_INS_WR : S_INS_FREE;
      S_INS_FREE: begin
        if (ring_idx_r == CW'(MAX_GROUPS)) state_nxt = S_DONE;
        else if (fill_r[free_g] == '0)
          state_nxt = (ring_count_r >= CW'(MAX_GROUPS)) ? S_DONE : S_INS_WR;
      end
      S_INS_WR: state_nxt = S_DONE;
      S_FREM_RD: state_nxt = idx_at_fcount ? S_DONE : S_FREM_PROC;
      S_FREM_PROC: state_nxt = S_FREM_RD;
      S_GREM_START: begin
        if (!ring_end) state_nxt = S_GREM_RD;
        else state_nxt = (total_r < TW'(FLAT_LIMIT)) ? S_FLAT_START : S_DONE;
      end
      S_GREM_RD: state_nxt = idx_at_fill ? S_GREM_START : S_GREM_PROC;
      S_GREM_PROC: state_nxt = S_GREM_RD;
      S_FLAT_START: state_nxt = ring_end ? S_DONE : S_FLAT_RD;
      S_FLAT_RD: state_nxt = idx_at_fill ? S_FLAT_START : S_FLAT_WR;
      S_FLAT_WR: state_nxt = S_FLAT_RD;
      S_FMARK_RD: state_nxt = idx_at_fcount ? S_DONE : S_FMARK_PROC;
      S_FMARK_PROC: state_nxt = rd_match ? S_DONE : S_FMARK_RD;
      S_GMARK_START: state_nxt = ring_end ? S_DONE : S_GMARK_RD;
      S_GMARK_RD: begin
        if (!idx_at_fill) state_nxt = S_GMARK_PROC;
        else state_nxt = found_r ? S_DONE : S_GMARK_START;
      end
      S_GMARK_PROC: state_nxt = S_GMARK_RD;
      S_FETCH_WAIT: state_nxt = S_DONE;
      S_CYC_WAIT: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_nxt = kind_r;
    id_nxt = id_r;
    status_nxt = status_r;
    last_nxt = last_r;
    period_nxt = period_r;
    fc_nxt = fc_r;
    grouped_nxt = grouped_r;
    total_nxt = total_r;
    fcount_nxt = fcount_r;
    fhead_nxt = fhead_r;
    fill_nxt = fill_r;
    gh_nxt = gh_r;
    ring_nxt = ring_r;
    stl_nxt = stl_r;
    ring_count_nxt = ring_count_r;
    ring_idx_nxt = ring_idx_r;
    keep_nxt = keep_r;
    g_nxt = g_r;
    best_nxt = best_r;
    best_fill_nxt = best_fill_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    found_nxt = found_r;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    if (cfg_valid && cfg_ready) period_nxt = cfg_data;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_data.kind;
          id_nxt = in_data.thread_id;
          status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        unique case (kind_r)
          KIND_INSERT: begin
            if (total_r >= TW'(CAP)) begin
              status_nxt = ST_FULL;
            end else if (grouped_r) begin
              ring_idx_nxt = '0;
              found_nxt = 1'b0;
              best_fill_nxt = FW'(GROUP_SIZE);
            end else if (total_r + TW'(1) < TW'(FLAT_LIMIT)) begin
              mem_we = 1'b1;
              mem_wa = flat_addr(fhead_r + fcount_r[3:0]);
              mem_wd = {1'b0, id_r};
              fcount_nxt = fcount_r + 5'd1;
              total_nxt = TW'(fcount_r) + TW'(1);
            end else begin
              for (int i = 0; i < MAX_GROUPS; i++) begin
                fill_nxt[i] = '0;
                gh_nxt[i] = '0;
              end
              stl_nxt = '0;
              ring_count_nxt = '0;
              idx_nxt = '0;
              cnt_nxt = '0;
              g_nxt = '0;
            end
          end
          KIND_REMOVE: begin
            idx_nxt = '0;
            cnt_nxt = '0;
            ring_idx_nxt = '0;
            keep_nxt = '0;
            if (grouped_r) total_nxt = '0;
          end
          KIND_STALL, KIND_UNSTALL: begin
            idx_nxt = '0;
            ring_idx_nxt = '0;
          end
          KIND_FETCH: begin
            if (!grouped_r) begin
              if (fcount_r == 5'd0) status_nxt = ST_EMPTY;
              mem_ra = flat_addr(fhead_r);
            end else if (ring_count_r == '0 || fill_r[head_g] == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              mem_ra = slot_addr(head_g, gh_r[head_g]);
            end
          end
          KIND_CYCLE: begin
            g_nxt = head_g;
            if (!grouped_r) begin
              mem_ra = flat_addr(fhead_r);
            end else if (ring_count_r != '0) begin
              if (stl_r[head_g]) begin
                if (ring_count_r >= CW'(2)) ring_nxt = ring_rot;
              end else begin
                mem_ra = slot_addr(head_g, gh_r[head_g]);
              end
            end
          end
          default: ;
        endcase
      end
      S_GRP_RD: mem_ra = flat_addr(fhead_r + idx_r[3:0]);
      S_GRP_WR: begin
        mem_we = 1'b1;
        mem_wa = slot_addr(g_r, cnt_r[PW-1:0]);
        mem_wd = {1'b0, (idx_r < NW'(fcount_r)) ? mem_rd_r[7:0] : id_r};
        fill_nxt[g_r] = g_fill + FW'(1);
        if (cnt_r == NW'(GROUP_SIZE - 1)) begin
          cnt_nxt = '0;
          g_nxt = g_r + GW'(1);
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
        idx_nxt = idx_r + NW'(1);
        if (idx_r == NW'(FLAT_LIMIT - 1)) begin
          for (int i = 0; i < MAX_GROUPS; i++) ring_nxt[i] = GW'(i);
          ring_count_nxt = CW'(INIT_GROUPS);
          fcount_nxt = '0;
          total_nxt = TW'(FLAT_LIMIT);
          grouped_nxt = 1'b1;
        end
      end
      S_INS_SCAN: begin
        if (ring_end) begin
          ring_idx_nxt = '0;
        end else begin
          if (fill_r[ring_at] < best_fill_r) begin
            best_nxt = ring_at;
            best_fill_nxt = fill_r[ring_at];
            found_nxt = 1'b1;
          end
          ring_idx_nxt = ring_idx_r + CW'(1);
        end
      end
      S_INS_FREE: begin
        if (ring_idx_r == CW'(MAX_GROUPS)) begin
          status_nxt = ST_FULL;
        end else if (fill_r[free_g] == '0) begin
          if (ring_count_r >= CW'(MAX_GROUPS)) begin
            status_nxt = ST_FULL;
          end else begin
            ring_nxt[ring_count_r[GW-1:0]] = free_g;
            ring_count_nxt = ring_count_r + CW'(1);
            best_nxt = free_g;
          end
        end else begin
          ring_idx_nxt = ring_idx_r + CW'(1);
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = slot_addr(best_r, wrap_add(gh_r[best_r], NW'(fill_r[best_r])));
        mem_wd = {1'b0, id_r};
        fill_nxt[best_r] = fill_r[best_r] + FW'(1);
        stl_nxt[best_r] = 1'b0;
        total_nxt = total_r + TW'(1);
      end
      S_FREM_RD: begin
        if (idx_at_fcount) begin
          fcount_nxt = cnt_r[4:0];
          total_nxt = TW'(cnt_r);
        end else begin
          mem_ra = flat_addr(fhead_r + idx_r[3:0]);
        end
      end
      S_FREM_PROC: begin
        if (!rd_match) begin
          mem_we = 1'b1;
          mem_wa = flat_addr(fhead_r + cnt_r[3:0]);
          mem_wd = mem_rd_r;
          cnt_nxt = cnt_r + NW'(1);
        end
        idx_nxt = idx_r + NW'(1);
      end
      S_GREM_START: begin
        if (ring_end) begin
          ring_count_nxt = keep_r;
          ring_idx_nxt = '0;
          cnt_nxt = '0;
        end else begin
          g_nxt = ring_at;
          idx_nxt = '0;
          cnt_nxt = '0;
          acc_nxt = 1'b1;
        end
      end
      S_GREM_RD: begin
        if (idx_at_fill) begin
          fill_nxt[g_r] = cnt_r[FW-1:0];
          stl_nxt[g_r] = (cnt_r != '0) && acc_r;
          total_nxt = total_r + TW'(cnt_r);
          if (cnt_r != '0) begin
            ring_nxt[keep_r[GW-1:0]] = g_r;
            keep_nxt = keep_r + CW'(1);
          end
          ring_idx_nxt = ring_idx_r + CW'(1);
        end else begin
          mem_ra = slot_addr(g_r, wrap_add(g_head, idx_r));
        end
      end
      S_GREM_PROC: begin
        if (!rd_match) begin
          mem_we = 1'b1;
          mem_wa = slot_addr(g_r, wrap_add(g_head, cnt_r));
          mem_wd = mem_rd_r;
          cnt_nxt = cnt_r + NW'(1);
          acc_nxt = acc_r & mem_rd_r[8];
        end
        idx_nxt = idx_r + NW'(1);
      end
      S_FLAT_START: begin
        if (ring_end) begin
          fcount_nxt = cnt_r[4:0];
          total_nxt = TW'(cnt_r);
          fhead_nxt = '0;
          for (int i = 0; i < MAX_GROUPS; i++) fill_nxt[i] = '0;
          stl_nxt = '0;
          ring_count_nxt = '0;
          grouped_nxt = 1'b0;
        end else begin
          g_nxt = ring_at;
          idx_nxt = '0;
        end
      end
      S_FLAT_RD: begin
        if (idx_at_fill) ring_idx_nxt = ring_idx_r + CW'(1);
        else mem_ra = slot_addr(g_r, wrap_add(g_head, idx_r));
      end
      S_FLAT_WR: begin
        mem_we = 1'b1;
        mem_wa = flat_addr(cnt_r[3:0]);
        mem_wd = mem_rd_r;
        cnt_nxt = cnt_r + NW'(1);
        idx_nxt = idx_r + NW'(1);
      end
      S_FMARK_RD: mem_ra = flat_addr(fhead_r + idx_r[3:0]);
      S_FMARK_PROC: begin
        if (rd_match) begin
          mem_we = 1'b1;
          mem_wa = flat_addr(fhead_r + idx_r[3:0]);
          mem_wd = mark_val;
        end
        idx_nxt = idx_r + NW'(1);
      end
      S_GMARK_START: begin
        g_nxt = ring_at;
        idx_nxt = '0;
        acc_nxt = 1'b1;
        found_nxt = 1'b0;
      end
      S_GMARK_RD: begin
        if (idx_at_fill) begin
          if (found_r) stl_nxt[g_r] = acc_r;
          else ring_idx_nxt = ring_idx_r + CW'(1);
        end else begin
          mem_ra = slot_addr(g_r, wrap_add(g_head, idx_r));
        end
      end
      S_GMARK_PROC: begin
        if (!found_r && rd_match) begin
          mem_we = 1'b1;
          mem_wa = slot_addr(g_r, wrap_add(g_head, idx_r));
          mem_wd = mark_val;
          found_nxt = 1'b1;
          acc_nxt = acc_r & mark_val[8];
        end else begin
          acc_nxt = acc_r & mem_rd_r[8];
        end
        idx_nxt = idx_r + NW'(1);
      end
      S_FETCH_WAIT: begin
        last_nxt = mem_rd_r[7:0];
        if (grouped_r) begin
          if (fc_inc >= period_r) begin
            fc_nxt = '0;
            if (ring_count_r >= CW'(2)) ring_nxt = ring_rot;
          end else begin
            fc_nxt = fc_inc;
          end
        end
      end
      S_CYC_WAIT: begin
        mem_we = 1'b1;
        mem_wd = mem_rd_r;
        if (grouped_r) begin
          mem_wa = slot_addr(g_r, wrap_add(g_head, NW'(g_fill)));
          gh_nxt[g_r] = wrap_add(g_head, NW'(1));
        end else begin
          mem_wa = flat_addr(fhead_r + fcount_r[3:0]);
          fhead_nxt = fhead_r + 4'd1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r != S_IDLE);
    cfg_ready = (state_r == S_IDLE);
    out_strobe = (state_r == S_DONE);
    out_data.fetched_thread = last_r;
    out_data.status = status_r;
    out_data.grouped_mode = grouped_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    mem_rd_r <= mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    kind_nxt_hold: begin
      kind_r <= kind_nxt;
      id_r <= id_nxt;
      ring_r <= ring_nxt;
      g_r <= g_nxt;
      best_r <= best_nxt;
      best_fill_r <= best_fill_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      keep_r <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      status_r <= ST_OK;
      last_r <= LAST_RST;
      period_r <= PERIOD_RST;
      fc_r <= '0;
      grouped_r <= 1'b0;
      total_r <= '0;
      fcount_r <= '0;
      fhead_r <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        fill_r[i] <= '0;
        gh_r[i] <= '0;
      end
      stl_r <= '0;
      ring_count_r <= '0;
      ring_idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      last_r <= last_nxt;
      period_r <= period_nxt;
      fc_r <= fc_nxt;
      grouped_r <= grouped_nxt;
      total_r <= total_nxt;
      fcount_r <= fcount_nxt;
      fhead_r <= fhead_nxt;
      fill_r <= fill_nxt;
      gh_r <= gh_nxt;
      stl_r <= stl_nxt;
      ring_count_r <= ring_count_nxt;
      ring_idx_r <= ring_idx_nxt;
      found_r <= found_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tlrr_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the two-level round-robin scheduler: watches command, result
// and config channels, predicts each result and compares; uses tlrr_pkg
module tlrr_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  tlrr_pkg::in_t  in_data,
  input  logic           out_strobe,
  input  tlrr_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [15:0]    cfg_data,
  output int             errors,
  output int             pending
);
  import tlrr_pkg::*;

  localparam int GSZ = 8;
  localparam int NGRP = 8;
  localparam int CAP = GSZ * NGRP;
  localparam int EXP_DEPTH = 16;

  logic [8:0]  flat [FLAT_LIMIT];
  int          flat_n;
  logic [8:0]  slots [CAP];
  int          fill [NGRP];
  int          gring [NGRP];
  int          gring_n;
  logic        gstall [NGRP];
  int          total;
  logic        grouped;
  logic [15:0] fetch_cnt;
  logic [7:0]  last_id;
  logic [15:0] period;
  out_t        exp_buf [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;

  assign pending = exp_wr - exp_rd;

  function automatic void refresh_group_stall(int g);
    logic all;
    all = fill[g] > 0;
    for (int i = 0; i < fill[g]; i++)
      if (!slots[g*GSZ+i][8]) all = 0;
    gstall[g] = all;
  endfunction

  function automatic void rotate_group_ring();
    int first;
    if (gring_n < 2) return;
    first = gring[0];
    for (int i = 0; i + 1 < gring_n; i++) gring[i] = gring[i+1];
    gring[gring_n-1] = first;
  endfunction

  function automatic void clear_all_groups();
    for (int g = 0; g < NGRP; g++) begin
      fill[g] = 0;
      gstall[g] = 0;
    end
    gring_n = 0;
  endfunction

  function automatic logic [1:0] sched_insert(logic [7:0] id);
    int best, best_fill, g;
    if (total >= CAP) return ST_FULL;
    if (!grouped) begin
      if (total + 1 < FLAT_LIMIT) begin
        flat[flat_n] = {1'b0, id};
        flat_n++;
        total = flat_n;
        return ST_OK;
      end
      clear_all_groups();
      for (int i = 0; i < FLAT_LIMIT; i++) begin
        g = i / GSZ;
        slots[g*GSZ+fill[g]] = (i < flat_n) ? {1'b0, flat[i][7:0]} : {1'b0, id};
        fill[g]++;
      end
      gring_n = 2;
      gring[0] = 0;
      gring[1] = 1;
      flat_n = 0;
      total = FLAT_LIMIT;
      grouped = 1;
      return ST_OK;
    end
    best = NGRP;
    best_fill = GSZ;
    for (int i = 0; i < gring_n; i++)
      if (fill[gring[i]] < best_fill) begin
        best = gring[i];
        best_fill = fill[gring[i]];
      end
    if (best == NGRP) begin
      for (g = 0; g < NGRP; g++)
        if (fill[g] == 0) break;
      if (g == NGRP || gring_n >= NGRP) return ST_FULL;
      best = g;
      gring[gring_n] = g;
      gring_n++;
    end
    slots[best*GSZ+fill[best]] = {1'b0, id};
    fill[best]++;
    refresh_group_stall(best);
    total++;
    return ST_OK;
  endfunction

  function automatic void sched_remove(logic [7:0] id);
    int k, keep, g, n;
    if (!grouped) begin
      k = 0;
      for (int i = 0; i < flat_n; i++)
        if (flat[i][7:0] != id) begin
          flat[k] = flat[i];
          k++;
        end
      flat_n = k;
      total = k;
      return;
    end
    keep = 0;
    total = 0;
    for (int i = 0; i < gring_n; i++) begin
      g = gring[i];
      k = 0;
      for (int j = 0; j < fill[g]; j++)
        if (slots[g*GSZ+j][7:0] != id) begin
          slots[g*GSZ+k] = slots[g*GSZ+j];
          k++;
        end
      fill[g] = k;
      refresh_group_stall(g);
      total += k;
      if (k > 0) begin
        gring[keep] = g;
        keep++;
      end
    end
    gring_n = keep;
    if (total < FLAT_LIMIT) begin
      n = 0;
      for (int i = 0; i < gring_n; i++) begin
        g = gring[i];
        for (int j = 0; j < fill[g] && n < FLAT_LIMIT; j++) begin
          flat[n] = slots[g*GSZ+j];
          n++;
        end
      end
      flat_n = n;
      total = n;
      clear_all_groups();
      grouped = 0;
    end
  endfunction

  function automatic void sched_mark(logic [7:0] id, logic stall);
    int g;
    if (!grouped) begin
      for (int i = 0; i < flat_n; i++)
        if (flat[i][7:0] == id) begin
          flat[i][8] = stall;
          return;
        end
      return;
    end
    for (int i = 0; i < gring_n; i++) begin
      g = gring[i];
      for (int j = 0; j < fill[g]; j++)
        if (slots[g*GSZ+j][7:0] == id) begin
          slots[g*GSZ+j][8] = stall;
          refresh_group_stall(g);
          return;
        end
    end
  endfunction

  function automatic logic [1:0] sched_fetch();
    int g;
    if (!grouped) begin
      if (flat_n == 0) return ST_EMPTY;
      last_id = flat[0][7:0];
      return ST_OK;
    end
    if (gring_n == 0) return ST_EMPTY;
    g = gring[0];
    if (fill[g] == 0) return ST_EMPTY;
    last_id = slots[g*GSZ][7:0];
    fetch_cnt = fetch_cnt + 16'd1;
    if (fetch_cnt >= period) begin
      rotate_group_ring();
      fetch_cnt = '0;
    end
    return ST_OK;
  endfunction

  function automatic void sched_cycle();
    logic [8:0] first;
    int g, n;
    if (!grouped) begin
      if (flat_n < 2) return;
      first = flat[0];
      for (int i = 0; i + 1 < flat_n; i++) flat[i] = flat[i+1];
      flat[flat_n-1] = first;
      return;
    end
    if (gring_n == 0) return;
    g = gring[0];
    if (gstall[g]) begin
      rotate_group_ring();
      return;
    end
    n = fill[g];
    if (n < 2) return;
    first = slots[g*GSZ];
    for (int i = 0; i + 1 < n; i++) slots[g*GSZ+i] = slots[g*GSZ+i+1];
    slots[g*GSZ+n-1] = first;
  endfunction

  function automatic out_t schedule_command(in_t cmd);
    out_t r;
    r.status = ST_OK;
    case (cmd.kind)
      KIND_INSERT:  r.status = sched_insert(cmd.thread_id);
      KIND_REMOVE:  sched_remove(cmd.thread_id);
      KIND_STALL:   sched_mark(cmd.thread_id, 1'b1);
      KIND_UNSTALL: sched_mark(cmd.thread_id, 1'b0);
      KIND_FETCH:   r.status = sched_fetch();
      KIND_CYCLE:   sched_cycle();
      default: ;
    endcase
    r.fetched_thread = last_id;
    r.grouped_mode = grouped;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      flat_n = 0;
      clear_all_groups();
      total = 0;
      grouped = 0;
      fetch_cnt = '0;
      last_id = LAST_RST;
      period = PERIOD_RST;
      errors = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (out_strobe) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected result transaction %h", out_data);
          errors++;
        end else begin
          exp_r = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_data.fetched_thread !== exp_r.fetched_thread) begin
            $error("fetched_thread exp %0d got %0d", exp_r.fetched_thread,
                   out_data.fetched_thread);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_data.status);
            errors++;
          end
          if (out_data.grouped_mode !== exp_r.grouped_mode) begin
            $error("grouped_mode exp %0d got %0d", exp_r.grouped_mode,
                   out_data.grouped_mode);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
          $error("too many result transactions outstanding");
          errors++;
        end else begin
          exp_buf[exp_wr % EXP_DEPTH] = schedule_command(in_data);
          exp_wr++;
        end
      end
      if (cfg_valid && cfg_ready) period = cfg_data;
    end
  end

endmodule

// ----- tb/sv/tb_two_level_round_robin_scheduler.sv -----
`timescale 1ns / 100ps
// testbench top for the two-level round-robin scheduler: clock, reset, command
// and config stimulus, verdict; uses tlrr_pkg and tlrr_checker
module tb_two_level_round_robin_scheduler;
  import tlrr_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_strobe;
  out_t        out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          gap_pct = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  two_level_round_robin_scheduler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tlrr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_command(logic [2:0] kind, logic [7:0] id);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= '{kind: kind, thread_id: id};
    do @(posedge clk); while (busy);
  endtask

  task automatic write_period(logic [15:0] value);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_commands(int count);
    int fill_bias;
    int roll;
    logic [2:0] kind;
    logic [7:0] id;
    fill_bias = 1;
    for (int n = 0; n < count; n++) begin
      if (n % 120 == 0) fill_bias = $urandom_range(0, 2);
      roll = $urandom_range(99);
      if (roll < 2) kind = 3'(6 + $urandom_range(1));
      else if (roll < 2 + (fill_bias == 2 ? 45 : fill_bias == 1 ? 25 : 10)) kind = KIND_INSERT;
      else if (roll < 60 - (fill_bias == 2 ? 10 : 0))
        kind = 3'(KIND_REMOVE + $urandom_range(2));
      else kind = 3'(KIND_FETCH + $urandom_range(1));
      if ((kind == KIND_REMOVE) && fill_bias == 2 && $urandom_range(1)) kind = KIND_STALL;
      id = ($urandom_range(9) < 8) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
      send_command(kind, id);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    write_period(16'd1);
    gap_pct = 36;
    send_command(KIND_FETCH, 8'h00);
    send_command(KIND_CYCLE, 8'h00);
    send_command(KIND_REMOVE, 8'h05);
    send_command(KIND_STALL, 8'h05);
    send_command(KIND_INSERT, 8'h00);
    send_command(KIND_INSERT, 8'hFF);
    send_command(KIND_INSERT, 8'hFF);
    send_command(KIND_STALL, 8'hFF);
    send_command(KIND_FETCH, 8'h00);
    send_command(KIND_CYCLE, 8'h00);
    send_command(KIND_FETCH, 8'hFF);
    send_command(KIND_UNSTALL, 8'hFF);
    send_command(KIND_REMOVE, 8'hFF);
    send_command(3'd6, 8'hAA);
    send_command(3'd7, 8'h55);
    for (int i = 1; i <= 15; i++) send_command(KIND_INSERT, 8'(i));
    for (int i = 0; i < 8; i++) send_command(KIND_STALL, 8'(i));
    send_command(KIND_CYCLE, 8'h00);
    send_command(KIND_FETCH, 8'h00);
    random_commands(350);
    write_period(16'd65535);
    gap_pct = 85;
    random_commands(350);
    write_period(16'd3);
    gap_pct = 0;
    random_commands(350);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tlrr_pkg.sv
design/two_level_round_robin_scheduler.sv
tb/sv/tlrr_checker.sv
tb/sv/tb_two_level_round_robin_scheduler.sv
